// File: hdl/setq_pkg.sv
package setq_pkg;

    localparam int SLOTS  = 32;
    localparam int SLOT_W = 5;
    localparam int TIME_W = 32;
    localparam int OP_W   = 2;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int S_TDATA_W = ((OP_W + SLOT_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_TICK
    } state_t;

    typedef struct packed {
        logic accept;
        logic insert;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic head_due;
        logic next_due;
        logic out_free;
    } sts_t;

endpackage

// File: hdl/sorted_expiry_timer_queue.sv
// Add: accept and unlink, then sorted insert into the shift chain.
// Adjust: unlink and sorted insert on a live slot, no change on an empty slot; delete: unlink only.
// Tick: the head is tested in the tick state, then one expired word per cycle leaves the
// head of the chain, stalled only by m_tready; each popped word is registered onto the output.
// Reset (aresetn low, synchronous) empties the list and drops any pending word.
module sorted_expiry_timer_queue
    import setq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // op[1:0], slot_id[6:2], time_value[38:7]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // expired_slot[4:0]
    output logic                 m_tlast
);

    cmd_t              cmd;
    sts_t              sts;
    op_t               in_op;
    logic [SLOT_W-1:0] in_slot;
    logic [TIME_W-1:0] in_time;
    logic [SLOT_W-1:0] out_slot;

    assign in_op   = op_t'(s_tdata[OP_W-1:0]);
    assign in_slot = s_tdata[OP_W +: SLOT_W];
    assign in_time = s_tdata[OP_W+SLOT_W +: TIME_W];

    setq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (in_op),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    setq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_op     (in_op),
        .in_slot   (in_slot),
        .in_time   (in_time),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_slot  (out_slot),
        .out_last  (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(out_slot);

endmodule

// File: hdl/setq_ctrl.sv
module setq_ctrl
    import setq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    input  op_t   in_op,
    input  sts_t  sts,
    output logic  in_ready,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_op)
                        OP_ADD:    state_next = ST_INSERT;
                        OP_ADJUST: state_next = sts.hit ? ST_INSERT : ST_IDLE;
                        OP_DELETE: state_next = ST_IDLE;
                        OP_TICK:   state_next = ST_TICK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INSERT: state_next = ST_IDLE;
            ST_TICK: begin
                if (!sts.head_due) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free && !sts.next_due) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_INSERT: cmd.insert = 1'b1;
            ST_TICK:   cmd.pop    = sts.head_due && sts.out_free;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/setq_datapath.sv
module setq_datapath
    import setq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  op_t               in_op,
    input  logic [SLOT_W-1:0] in_slot,
    input  logic [TIME_W-1:0] in_time,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SLOT_W-1:0] out_slot,
    output logic              out_last
);

    logic [SLOT_W-1:0] slot_reg [SLOTS];
    logic [TIME_W-1:0] exp_reg  [SLOTS];
    logic [SLOT_W-1:0] slot_up  [SLOTS];
    logic [TIME_W-1:0] exp_up   [SLOTS];
    logic [SLOT_W-1:0] slot_dn  [SLOTS];
    logic [TIME_W-1:0] exp_dn   [SLOTS];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] op_slot_reg;
    logic [TIME_W-1:0] op_time_reg;
    logic              out_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_last_reg;

    logic [SLOTS-1:0]  live;
    logic [SLOTS-1:0]  match;
    logic [SLOTS-1:0]  above;
    logic [SLOTS-1:0]  le;
    logic [SLOTS-1:0]  le_prev;
    logic              remove;
    logic              slot_ok;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_nbr
            if (g < SLOTS - 1) begin : g_up
                assign slot_up[g] = slot_reg[g+1];
                assign exp_up[g]  = exp_reg[g+1];
            end else begin : g_up_end
                assign slot_up[g] = slot_reg[g];
                assign exp_up[g]  = exp_reg[g];
            end
            if (g > 0) begin : g_dn
                assign slot_dn[g] = slot_reg[g-1];
                assign exp_dn[g]  = exp_reg[g-1];
            end else begin : g_dn_end
                assign slot_dn[g] = slot_reg[g];
                assign exp_dn[g]  = exp_reg[g];
            end
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            live[i]  = CNT_W'(i) < count_reg;
            match[i] = live[i] && (slot_reg[i] == in_slot);
            le[i]    = live[i] && (exp_reg[i] <= op_time_reg);
        end
        above[0] = match[0];
        for (int i = 1; i < SLOTS; i++) begin
            above[i] = above[i-1] | match[i];
        end
        le_prev = {le[SLOTS-2:0], 1'b1};
    end

    assign slot_ok = ({1'b0, in_slot} < CNT_W'(SLOTS));
    assign remove  = cmd.accept && (in_op != OP_TICK) && slot_ok && (|match);

    assign sts.hit      = slot_ok && (|match);
    assign sts.head_due = (count_reg != '0) && (exp_reg[0] <= op_time_reg);
    assign sts.next_due = (count_reg > CNT_W'(1)) && (exp_reg[1] <= op_time_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb begin
        count_next = count_reg;
        if (remove || cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.insert && (count_reg < CNT_W'(SLOTS))) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_slot_reg <= in_slot;
            op_time_reg <= in_time;
        end
        if (cmd.pop) begin
            out_slot_reg <= slot_reg[0];
            out_last_reg <= !sts.next_due;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (remove) begin
                if (above[i]) begin
                    slot_reg[i] <= slot_up[i];
                    exp_reg[i]  <= exp_up[i];
                end
            end else if (cmd.pop) begin
                slot_reg[i] <= slot_up[i];
                exp_reg[i]  <= exp_up[i];
            end else if (cmd.insert && (count_reg < CNT_W'(SLOTS))) begin
                if (!le[i] && le_prev[i]) begin
                    slot_reg[i] <= op_slot_reg;
                    exp_reg[i]  <= op_time_reg;
                end else if (!le[i]) begin
                    slot_reg[i] <= slot_dn[i];
                    exp_reg[i]  <= exp_dn[i];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("live count beyond capacity");

    a_pop_due: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (count_reg != '0) && (exp_reg[0] <= op_time_reg))
        else $error("pop of a head that is not due");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not shrink the list");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> count_reg < CNT_W'(SLOTS))
        else $error("insert into a full list");
`endif

endmodule

// File: tb/setq_checker.sv
module setq_checker
    import setq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              last;
    } expired_word_t;

    logic [TIME_W-1:0] timer_expiry [SLOTS];
    logic              timer_live   [SLOTS];
    logic [SLOT_W-1:0] timer_order_q[$];
    expired_word_t     due_slots_q[$];
    expired_word_t     head_word;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic void unlink_timer(logic [SLOT_W-1:0] slot);
        int idx;
        for (idx = 0; idx < timer_order_q.size(); idx++) begin
            if (timer_order_q[idx] == slot) begin
                timer_order_q.delete(idx);
                break;
            end
        end
        timer_live[slot] = 1'b0;
    endfunction

    function automatic void place_timer(logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] expiry);
        int pos;
        pos = 0;
        while (pos < timer_order_q.size() && timer_expiry[timer_order_q[pos]] <= expiry)
            pos++;
        timer_order_q.insert(pos, slot);
        timer_expiry[slot] = expiry;
        timer_live[slot]   = 1'b1;
    endfunction

    function automatic void apply_timer_op(op_t op, logic [SLOT_W-1:0] slot,
                                           logic [TIME_W-1:0] tv);
        int n;
        expired_word_t w;
        case (op)
            OP_ADD: begin
                if (timer_live[slot])
                    unlink_timer(slot);
                place_timer(slot, tv);
            end
            OP_ADJUST: begin
                if (timer_live[slot]) begin
                    unlink_timer(slot);
                    place_timer(slot, tv);
                end
            end
            OP_DELETE: begin
                if (timer_live[slot])
                    unlink_timer(slot);
            end
            default: begin
                n = 0;
                while (n < timer_order_q.size() && timer_expiry[timer_order_q[n]] <= tv)
                    n++;
                for (int i = 0; i < n; i++) begin
                    w.slot = timer_order_q[i];
                    w.last = (i == n - 1);
                    due_slots_q.push_back(w);
                    timer_live[timer_order_q[i]] = 1'b0;
                end
                repeat (n) void'(timer_order_q.pop_front());
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (timer_live[i]) timer_live[i] = 1'b0;
            timer_order_q.delete();
            due_slots_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_slots_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected expired word, expected none, actual slot %0d last %0b",
                             $time, m_tdata[SLOT_W-1:0], m_tlast);
                end else begin
                    head_word = due_slots_q.pop_front();
                    if (head_word.slot !== m_tdata[SLOT_W-1:0] || head_word.last !== m_tlast) begin
                        fail_count++;
                        $display("%0t: expired word mismatch, expected slot %0d last %0b, actual slot %0d last %0b",
                                 $time, head_word.slot, head_word.last,
                                 m_tdata[SLOT_W-1:0], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_timer_op(op_t'(s_tdata[OP_W-1:0]), s_tdata[OP_W +: SLOT_W],
                               s_tdata[OP_W+SLOT_W +: TIME_W]);
        end
        outstanding <= due_slots_q.size();
    end

endmodule

// File: tb/tb.sv
module tb
    import setq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int                   fail_count;
    int                   outstanding;
    int                   send_idle_pct = 6;
    int                   recv_idle_pct = 54;
    logic [TIME_W-1:0]    now_time;

    sorted_expiry_timer_queue DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    setq_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("tb failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_word(op_t op, logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] tv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({tv, slot, op});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic fill_and_expire();
        logic [TIME_W-1:0] base;
        base = now_time;
        for (int s = 0; s < SLOTS; s++)
            send_word(OP_ADD, SLOT_W'(s), base + $urandom_range(0, 3));
        now_time = base + 3;
        send_word(OP_TICK, SLOT_W'($urandom), now_time);
    endtask

    task automatic random_word();
        int                r;
        logic [SLOT_W-1:0] slot;
        r    = $urandom_range(0, 99);
        slot = SLOT_W'($urandom_range(0, SLOTS - 1));
        if (r < 40) begin
            send_word(OP_ADD, slot, now_time + $urandom_range(0, 40));
        end else if (r < 55) begin
            send_word(OP_ADJUST, slot, now_time + $urandom_range(0, 60));
        end else if (r < 65) begin
            send_word(OP_DELETE, slot, $urandom);
        end else if (r < 85) begin
            now_time = now_time + $urandom_range(0, 25);
            send_word(OP_TICK, slot, now_time);
        end else begin
            send_word(op_t'($urandom_range(0, 3)), slot, $urandom);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_word(OP_TICK,   5'd0,  32'd0);
        send_word(OP_ADD,    5'd0,  32'd0);
        send_word(OP_ADD,    5'd31, 32'hFFFF_FFFF);
        send_word(OP_ADD,    5'd5,  32'd100);
        send_word(OP_ADD,    5'd6,  32'd100);
        send_word(OP_ADD,    5'd7,  32'd100);
        send_word(OP_ADJUST, 5'd31, 32'd50);
        send_word(OP_ADJUST, 5'd9,  32'd0);
        send_word(OP_DELETE, 5'd10, 32'hFFFF_FFFF);
        send_word(OP_ADD,    5'd5,  32'd100);
        send_word(OP_DELETE, 5'd6,  32'd0);
        send_word(OP_TICK,   5'd31, 32'd0);
        send_word(OP_TICK,   5'd0,  32'd49);
        send_word(OP_TICK,   5'd0,  32'd100);
        send_word(OP_ADD,    5'd12, 32'd300);
        send_word(OP_ADD,    5'd13, 32'd200);
        send_word(OP_ADJUST, 5'd12, 32'd150);
        send_word(OP_ADJUST, 5'd13, 32'd400);
        send_word(OP_ADD,    5'd20, 32'h8000_0000);
        send_word(OP_ADD,    5'd21, 32'h7FFF_FFFF);
        send_word(OP_TICK,   5'd0,  32'hFFFF_FFFF);

        // hold the sender until every expired word is out
        drain_results();

        now_time = $urandom_range(0, 1000);
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            fill_and_expire();
            repeat (83) random_word();
            if (phase == 0)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
